// ----- design/assert_macros.svh -----
// Assertion helpers shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge once out of reset.
`define CDS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clk edge, reset included.
`define CDS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/cds_pkg.sv -----
package cds_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int ORD_W   = 9;
  localparam int WD_W    = 3;

  // Year shifted by 400 (and back one for January/February), and its quarter
  localparam int WY_W = 15;
  localparam int QA_W = WY_W - 2;
  localparam int QB_W = YEAR_W - 2;

  // Divide by 25 as multiply by ceil(2^17 / 25) then shift
  localparam int                RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_25   = 13'd5243;
  localparam int                RECIP_SHIFT = 17;
  localparam int                PA_W        = QA_W + RECIP_W;
  localparam int                PB_W        = QB_W + RECIP_W;
  localparam int                Q100_W      = PA_W - RECIP_SHIFT;
  localparam int                QB25_W      = PB_W - RECIP_SHIFT;

  localparam logic [WY_W-1:0] YEAR_OFFSET = 15'd400;
  localparam int              WSUM_W      = 15;
  localparam int              ZT_W        = 6;

  localparam logic [MONTH_W-1:0] MONTH_JAN       = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB       = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR       = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_DEC       = 4'd12;
  localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [WY_W-1:0]    wy;
    logic [PA_W-1:0]    pa;
    logic [PB_W-1:0]    pb;
  } s1_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               leap;
    logic [WSUM_W-1:0]  wsum;
  } s2_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  next_year;
    logic [MONTH_W-1:0] next_month;
    logic [DAY_W-1:0]   next_day;
    logic [YEAR_W-1:0]  prev_year;
    logic [MONTH_W-1:0] prev_month;
    logic [DAY_W-1:0]   prev_day;
    logic [ORD_W-1:0]   ordinal_day;
    logic [WD_W-1:0]    weekday;
  } res_t;

  // Common-year month length; codes outside 1..12 count as 31 days
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:                 len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:              len = 5'd31;
    endcase
    return len;
  endfunction

  // Days in the months before m in a common year
  function automatic logic [ORD_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
    logic [ORD_W-1:0] c;
    case (m)
      4'd0, 4'd1: c = 9'd0;
      4'd2:       c = 9'd31;
      4'd3:       c = 9'd59;
      4'd4:       c = 9'd90;
      4'd5:       c = 9'd120;
      4'd6:       c = 9'd151;
      4'd7:       c = 9'd181;
      4'd8:       c = 9'd212;
      4'd9:       c = 9'd243;
      4'd10:      c = 9'd273;
      4'd11:      c = 9'd304;
      4'd12:      c = 9'd334;
      4'd13:      c = 9'd365;
      4'd14:      c = 9'd396;
      default:    c = 9'd427;
    endcase
    return c;
  endfunction

  // (13 * wm + 8) / 5 for the shifted month
  function automatic logic [ZT_W-1:0] zeller_term(input logic [MONTH_W-1:0] wm);
    logic [ZT_W-1:0] t;
    case (wm)
      4'd0:    t = 6'd1;
      4'd1:    t = 6'd4;
      4'd2:    t = 6'd6;
      4'd3:    t = 6'd9;
      4'd4:    t = 6'd12;
      4'd5:    t = 6'd14;
      4'd6:    t = 6'd17;
      4'd7:    t = 6'd19;
      4'd8:    t = 6'd22;
      4'd9:    t = 6'd25;
      4'd10:   t = 6'd27;
      4'd11:   t = 6'd30;
      4'd12:   t = 6'd32;
      4'd13:   t = 6'd35;
      4'd14:   t = 6'd38;
      default: t = 6'd40;
    endcase
    return t;
  endfunction

endpackage

// ----- design/cds_recip_stage.sv -----
`include "assert_macros.svh"

module cds_recip_stage (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  input  logic [cds_pkg::YEAR_W-1:0]   up_year,
  input  logic [cds_pkg::MONTH_W-1:0]  up_month,
  input  logic [cds_pkg::DAY_W-1:0]    up_day,
  output logic                         up_ready,
  output logic                         dn_valid,
  output cds_pkg::s1_t                 dn_data,
  input  logic                         dn_ready
);
  import cds_pkg::*;

  logic            valid_r;
  s1_t             data_r;
  s1_t             data_nxt;
  logic            jan_feb;
  logic [QA_W-1:0] qa;
  logic [QB_W-1:0] qb;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    jan_feb        = (up_month == MONTH_JAN) || (up_month == MONTH_FEB);
    data_nxt.year  = up_year;
    data_nxt.month = up_month;
    data_nxt.day   = up_day;
    data_nxt.wy    = WY_W'(up_year) + YEAR_OFFSET - WY_W'(jan_feb);
    qa             = data_nxt.wy[WY_W-1:2];
    qb             = up_year[YEAR_W-1:2];
    data_nxt.pa    = PA_W'(qa) * PA_W'(RECIP_25);
    data_nxt.pb    = PB_W'(qb) * PB_W'(RECIP_25);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  `CDS_ASSERT(a_s1_hold, valid_r && !dn_ready |=> valid_r && $stable(data_r), "stage 1 lost a held item")

endmodule

// ----- design/cds_leap_stage.sv -----
`include "assert_macros.svh"

module cds_leap_stage (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         up_valid,
  input  cds_pkg::s1_t up_data,
  output logic         up_ready,
  output logic         dn_valid,
  output cds_pkg::s2_t dn_data,
  input  logic         dn_ready
);
  import cds_pkg::*;

  logic                valid_r;
  s2_t                 data_r;
  s2_t                 data_nxt;
  logic [Q100_W-1:0]   q100;
  logic [QB25_W-1:0]   q25;
  logic [QB_W-1:0]     qb;
  logic [QB_W-1:0]     rem25;
  logic                jan_feb;
  logic [MONTH_W-1:0]  wm;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    q100    = up_data.pa[PA_W-1:RECIP_SHIFT];
    q25     = up_data.pb[PB_W-1:RECIP_SHIFT];
    qb      = up_data.year[YEAR_W-1:2];
    rem25   = qb - QB_W'(QB_W'(q25) * QB_W'(25));
    jan_feb = (up_data.month == MONTH_JAN) || (up_data.month == MONTH_FEB);
    wm      = jan_feb ? (up_data.month + MONTHS_PER_YEAR) : up_data.month;

    data_nxt.year  = up_data.year;
    data_nxt.month = up_data.month;
    data_nxt.day   = up_data.day;
    // divisible by 4, and not by 100 unless by 400
    data_nxt.leap  = (up_data.year[1:0] == 2'b00) &&
                     ((rem25 != '0) || (up_data.year[3:2] == 2'b00));
    data_nxt.wsum  = WSUM_W'(up_data.wy) + WSUM_W'(up_data.wy[WY_W-1:2])
                   - WSUM_W'(q100) + WSUM_W'(q100[Q100_W-1:2])
                   + WSUM_W'(zeller_term(wm)) + WSUM_W'(up_data.day);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  `CDS_ASSERT(a_leap_mult4, valid_r && data_r.leap |-> data_r.year[1:0] == 2'b00, "leap year not a multiple of four")

endmodule

// ----- design/cds_out_stage.sv -----
`include "assert_macros.svh"

module cds_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  input  cds_pkg::s2_t  up_data,
  output logic          up_ready,
  output logic          dn_valid,
  output cds_pkg::res_t dn_data,
  input  logic          dn_ready
);
  import cds_pkg::*;

  logic             valid_r;
  res_t             res_r;
  res_t             res_nxt;
  logic [DAY_W-1:0] cur_len;
  logic [5:0]       fold1;
  logic [3:0]       fold2;
  logic [2:0]       fold3;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = res_r;

  always_comb begin
    cur_len = month_len(up_data.month) +
              DAY_W'((up_data.month == MONTH_FEB) && up_data.leap);

    // following day
    res_nxt.next_year  = up_data.year;
    res_nxt.next_month = up_data.month;
    res_nxt.next_day   = up_data.day + DAY_W'(1);
    if (up_data.day >= cur_len) begin
      res_nxt.next_day = DAY_W'(1);
      if (up_data.month >= MONTH_DEC) begin
        res_nxt.next_year  = up_data.year + YEAR_W'(1);
        res_nxt.next_month = MONTH_JAN;
      end else begin
        res_nxt.next_month = up_data.month + MONTH_W'(1);
      end
    end

    // preceding day
    res_nxt.prev_year  = up_data.year;
    res_nxt.prev_month = up_data.month;
    res_nxt.prev_day   = up_data.day - DAY_W'(1);
    if (up_data.day <= DAY_W'(1)) begin
      if (up_data.month <= MONTH_JAN) begin
        res_nxt.prev_year  = up_data.year - YEAR_W'(1);
        res_nxt.prev_month = MONTH_DEC;
      end else begin
        res_nxt.prev_month = up_data.month - MONTH_W'(1);
      end
      res_nxt.prev_day = month_len(res_nxt.prev_month) +
                         DAY_W'((res_nxt.prev_month == MONTH_FEB) && up_data.leap);
    end

    res_nxt.ordinal_day = ORD_W'(up_data.day) + cum_days(up_data.month) +
                          ORD_W'(up_data.leap && (up_data.month >= MONTH_MAR));

    // mod 7 by summing octal digits
    fold1 = 6'(up_data.wsum[2:0]) + 6'(up_data.wsum[5:3]) + 6'(up_data.wsum[8:6])
          + 6'(up_data.wsum[11:9]) + 6'(up_data.wsum[14:12]);
    fold2 = 4'(fold1[5:3]) + 4'(fold1[2:0]);
    fold3 = 3'(fold2[3]) + fold2[2:0];
    res_nxt.weekday = (fold3 == 3'd7) ? 3'd0 : fold3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      res_r <= res_nxt;
    end
  end

  `CDS_ASSERT(a_wd_range, valid_r |-> res_r.weekday != 3'd7, "weekday out of range")
  `CDS_ASSERT(a_day_nonzero, valid_r |-> res_r.next_day != '0 && res_r.prev_day != '0, "zero day of month")

endmodule

// ----- design/calendar_date_step_top.sv -----
// Gregorian date stepper. For each date item (year, month, day of month) it
// returns one result item holding the following day, the preceding day, the
// day number within the year and the weekday (0 is Sunday). Leap years follow
// the full Gregorian rule. The block is a three-stage pipeline: stage one
// forms the weekday year and runs two constant-reciprocal multipliers that
// divide by 25; stage two settles the leap flag and the weekday sum; stage
// three, which is also the output register, does the month roll-over, the
// day number and the reduction mod 7. It takes one item every cycle while the
// output is not stalled; an accepted item passes through the stage one, stage
// two and output registers in turn, and its result is held there until taken.
// The reciprocal multipliers in stage one set the clock period.
// A stall on the output holds each stage that has a valid item and lets empty
// stages fill, so in_stall rises only when all three stages are full and
// blocked. Month codes outside 1..12 count as 31-day months, and years wrap
// at 14 bits.
`include "assert_macros.svh"

module calendar_date_step_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [cds_pkg::YEAR_W-1:0]   in_year,
  input  logic [cds_pkg::MONTH_W-1:0]  in_month,
  input  logic [cds_pkg::DAY_W-1:0]    in_day_of_month,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [cds_pkg::YEAR_W-1:0]   out_next_year,
  output logic [cds_pkg::MONTH_W-1:0]  out_next_month,
  output logic [cds_pkg::DAY_W-1:0]    out_next_day,
  output logic [cds_pkg::YEAR_W-1:0]   out_prev_year,
  output logic [cds_pkg::MONTH_W-1:0]  out_prev_month,
  output logic [cds_pkg::DAY_W-1:0]    out_prev_day,
  output logic [cds_pkg::ORD_W-1:0]    out_ordinal_day,
  output logic [cds_pkg::WD_W-1:0]     out_weekday
);
  import cds_pkg::*;

  logic s1_valid;
  logic s1_ready;
  s1_t  s1_data;
  logic s2_valid;
  logic s2_ready;
  s2_t  s2_data;
  logic s3_ready;
  res_t res;

  // Stage one: weekday year and divide-by-25 products
  cds_recip_stage u_recip (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_year  (in_year),
    .up_month (in_month),
    .up_day   (in_day_of_month),
    .up_ready (s1_ready),
    .dn_valid (s1_valid),
    .dn_data  (s1_data),
    .dn_ready (s2_ready)
  );

  // Stage two: leap flag and weekday sum
  cds_leap_stage u_leap (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_data  (s1_data),
    .up_ready (s2_ready),
    .dn_valid (s2_valid),
    .dn_data  (s2_data),
    .dn_ready (s3_ready)
  );

  // Stage three: date arithmetic, held as the output register
  cds_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_data  (s2_data),
    .up_ready (s3_ready),
    .dn_valid (out_valid),
    .dn_data  (res),
    .dn_ready (!out_stall)
  );

  // Hold the input side only when stage one cannot move on
  assign in_stall = !s1_ready;

  assign out_next_year   = res.next_year;
  assign out_next_month  = res.next_month;
  assign out_next_day    = res.next_day;
  assign out_prev_year   = res.prev_year;
  assign out_prev_month  = res.prev_month;
  assign out_prev_day    = res.prev_day;
  assign out_ordinal_day = res.ordinal_day;
  assign out_weekday     = res.weekday;

  `CDS_ASSERT(a_full_stall, s1_valid && s2_valid && out_valid && out_stall |-> in_stall, "full blocked pipeline took an item")
  `CDS_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid && !s1_valid && !s2_valid, "pipeline not empty after reset")

endmodule
